// ----- rtl/binary_neighbor_noise_filter_unit_macros.svh -----
// Assertion macros shared by the noise filter modules.
`ifndef BINARY_NEIGHBOR_NOISE_FILTER_UNIT_MACROS_SVH
`define BINARY_NEIGHBOR_NOISE_FILTER_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BNNF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never occurs.
`define BNNF_NEVER(lbl, cond, msg) \
  `BNNF_ASSERT(lbl, !(cond), msg)

`endif

// ----- rtl/bnnf_pkg.sv -----
// Types, constants and filter functions of the binary neighbor noise filter.
package bnnf_pkg;

  localparam int unsigned MaxRows       = 64;
  localparam int unsigned ColW          = 64;
  localparam int unsigned ShW           = $clog2(ColW);
  localparam int unsigned HeightW       = 7;
  localparam int unsigned MinHeight     = 3;
  localparam int unsigned QueueDepthDef = 4;
  localparam int unsigned PAddrW        = 3;
  localparam int unsigned PDataW        = 32;

  localparam logic [HeightW-1:0] HeightReset = HeightW'(MaxRows);
  localparam logic               RegHeight   = 1'b0;

  typedef enum logic [1:0] {
    KindFirst,
    KindSecond,
    KindThird,
    KindSteady
  } kind_e;

  typedef struct packed {
    logic [ColW-1:0] column_bits;
    logic            last_column;
  } in_item_t;

  typedef struct packed {
    logic [ColW-1:0] filtered_bits;
    logic            final_column;
  } out_item_t;

  typedef struct packed {
    logic [ColW-1:0] col;
    logic            last;
    kind_e           kind;
  } entry_t;

  typedef struct packed {
    logic [ColW-1:0] row_mask;
    logic [ColW-1:0] int_mask;
  } masks_t;

  function automatic masks_t masks_from_height(input logic [HeightW-1:0] h);
    logic [HeightW-1:0] eff;
    logic [HeightW-1:0] top_row;
    masks_t             m;
    eff     = (h > HeightW'(MaxRows)) ? HeightW'(MaxRows) : h;
    top_row = eff - HeightW'(1);
    if (eff >= HeightW'(ColW)) begin
      m.row_mask = '1;
    end else begin
      m.row_mask = (ColW'(1) << eff[ShW-1:0]) - ColW'(1);
    end
    if (eff < HeightW'(MinHeight)) begin
      m.int_mask = '0;
    end else begin
      m.int_mask = m.row_mask & ~ColW'(1) & ~(ColW'(1) << top_row[ShW-1:0]);
    end
    return m;
  endfunction

  // Clear white pixels with a black vertical neighbor or black left and right.
  function automatic logic [ColW-1:0] pass_one(input logic [ColW-1:0] l,
                                               input logic [ColW-1:0] c,
                                               input logic [ColW-1:0] r,
                                               input logic [ColW-1:0] int_mask);
    logic [ColW-1:0] kill;
    kill = ~(c << 1) | ~(c >> 1) | (~l & ~r);
    return c & ~(int_mask & kill);
  endfunction

  // Clear isolated white pixels; a cleared pixel never enables its neighbor.
  function automatic logic [ColW-1:0] pass_two(input logic [ColW-1:0] l,
                                               input logic [ColW-1:0] c,
                                               input logic [ColW-1:0] r,
                                               input logic [ColW-1:0] int_mask);
    logic [ColW-1:0] kill;
    kill = c & ~(c << 1) & ~(c >> 1) & ~l & ~r;
    return c & ~(int_mask & kill);
  endfunction

endpackage

// ----- rtl/bnnf_queue.sv -----
// Short queue of classified columns between front and back.
`include "binary_neighbor_noise_filter_unit_macros.svh"

module bnnf_queue #(
  parameter int unsigned Depth = bnnf_pkg::QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bnnf_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output bnnf_pkg::entry_t entry_o
);
  import bnnf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `BNNF_ASSERT(a_count_bound, count_q <= CntW'(Depth), "queue count beyond depth")
  `BNNF_ASSERT(a_count_up, push_i && !pop_i |=> count_q == $past(count_q) + CntW'(1), "queue count did not advance")
  `BNNF_ASSERT(a_empty_ptrs, count_q == '0 |-> rd_ptr_q == wr_ptr_q, "empty queue with split pointers")

endmodule

// ----- rtl/bnnf_front.sv -----
// Input side: masks each column and tags it with its place in the image.
module bnnf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bnnf_pkg::in_item_t in_item_i,
  input  bnnf_pkg::masks_t   masks_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output bnnf_pkg::entry_t   q_entry_o
);
  import bnnf_pkg::*;

  kind_e seen_q, seen_d;
  logic  accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  assign q_entry_o.col  = in_item_i.column_bits & masks_i.row_mask;
  assign q_entry_o.last = in_item_i.last_column;
  assign q_entry_o.kind = seen_q;

  always_comb begin
    seen_d = seen_q;
    if (accept) begin
      if (in_item_i.last_column) begin
        seen_d = KindFirst;
      end else begin
        unique case (seen_q)
          KindFirst:  seen_d = KindSecond;
          KindSecond: seen_d = KindThird;
          KindThird:  seen_d = KindSteady;
          KindSteady: seen_d = KindSteady;
          default:    seen_d = KindFirst;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= KindFirst;
    end else begin
      seen_q <= seen_d;
    end
  end

endmodule

// ----- rtl/bnnf_back.sv -----
// Output side: runs both filter passes and emits the columns they release.
`include "binary_neighbor_noise_filter_unit_macros.svh"

module bnnf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  bnnf_pkg::entry_t    head_i,
  output logic                pop_o,
  input  bnnf_pkg::masks_t    masks_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bnnf_pkg::out_item_t out_item_o
);
  import bnnf_pkg::*;

  logic [ColW-1:0] op_q, op_d;
  logic [ColW-1:0] op2_q, op2_d;
  logic [ColW-1:0] fp_q, fp_d;
  logic [ColW-1:0] sp_q, sp_d;
  logic [1:0]      idx_q, idx_d;
  logic            out_vld_q, out_vld_d;
  out_item_t       out_q, out_d;

  logic [ColW-1:0] p1_mid, p2_mid, p2_out, p2_last;
  out_item_t       res0, res1, res2, cur;
  logic [1:0]      cnt;
  logic            out_ready;
  logic            load;

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;
  assign out_ready   = !out_vld_q || !out_stall_i;

  always_comb begin
    p1_mid  = pass_one(op2_q, op_q, head_i.col, masks_i.int_mask);
    p2_mid  = pass_two(sp_q, fp_q, p1_mid, masks_i.int_mask);
    p2_out  = (head_i.kind == KindThird) ? fp_q : p2_mid;
    p2_last = pass_two(p2_out, p1_mid, head_i.col, masks_i.int_mask);
  end

  always_comb begin
    res0 = '0;
    res1 = '0;
    res2 = '0;
    cnt  = 2'd0;
    unique case (head_i.kind)
      KindFirst: begin
        cnt  = head_i.last ? 2'd1 : 2'd0;
        res0 = '{filtered_bits: head_i.col, final_column: 1'b1};
      end
      KindSecond: begin
        cnt  = head_i.last ? 2'd2 : 2'd0;
        res0 = '{filtered_bits: op_q, final_column: 1'b0};
        res1 = '{filtered_bits: head_i.col, final_column: 1'b1};
      end
      KindThird, KindSteady: begin
        cnt  = head_i.last ? 2'd3 : 2'd1;
        res0 = '{filtered_bits: p2_out, final_column: 1'b0};
        res1 = '{filtered_bits: p2_last, final_column: 1'b0};
        res2 = '{filtered_bits: head_i.col, final_column: 1'b1};
      end
      default: cnt = 2'd0;
    endcase
    unique case (idx_q)
      2'd0:    cur = res0;
      2'd1:    cur = res1;
      default: cur = res2;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    load  = 1'b0;
    idx_d = idx_q;
    if (head_valid_i) begin
      if (cnt == 2'd0) begin
        pop_o = 1'b1;
      end else if (out_ready) begin
        load = 1'b1;
        if (idx_q == cnt - 2'd1) begin
          pop_o = 1'b1;
          idx_d = 2'd0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
    end
  end

  always_comb begin
    op_d  = op_q;
    op2_d = op2_q;
    fp_d  = fp_q;
    sp_d  = sp_q;
    if (pop_o) begin
      unique case (head_i.kind)
        KindFirst: begin
          op_d = head_i.col;
        end
        KindSecond: begin
          fp_d  = op_q;
          op2_d = op_q;
          op_d  = head_i.col;
        end
        KindThird, KindSteady: begin
          sp_d  = p2_out;
          fp_d  = p1_mid;
          op2_d = op_q;
          op_d  = head_i.col;
        end
        default: op_d = op_q;
      endcase
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (load) begin
      out_vld_d = 1'b1;
      out_d     = cur;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= 2'd0;
      out_vld_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    op2_q <= op2_d;
    fp_q  <= fp_d;
    sp_q  <= sp_d;
    out_q <= out_d;
  end

  `BNNF_NEVER(a_idx_needs_head, !head_valid_i && idx_q != 2'd0, "partial item without head")
  `BNNF_ASSERT(a_idx_only_last, head_valid_i && idx_q != 2'd0 |-> head_i.last, "multi result item not last")
  `BNNF_ASSERT(a_last_is_final, pop_o && head_i.last |=> out_vld_q && out_q.final_column, "last item did not end final")

endmodule

// ----- rtl/binary_neighbor_noise_filter_unit.sv -----
// Top level of the binary neighbor noise filter with its register port.
//
// Columns of a binary image enter on in_valid_i/in_item_i, one per cycle while
// in_stall_o is low, bit j being row j and 1 meaning white. Filtered columns
// leave on out_valid_o/out_item_o. An item moves when valid is high and stall
// low. A column is output two columns after it enters; the column marked
// last_column flushes the rest of the image, the final one carrying
// final_column, and the next column starts a new image.
// An item is held in the queue, then its results in the output register.
// Throughput: one column per cycle while out_stall_i is low; a last column
// releases up to three results, one per cycle from the single output register.
// A four-entry queue holds columns while the output is stalled; when it is
// full, in_stall_o rises. The output holds its item while out_stall_i is high.
// Register image_height sits at byte address 0 (reset 64, values above 64
// act as 64); write it only while the block is empty.
// Reset empties the queue and output and starts a new image.
module binary_neighbor_noise_filter_unit #(
  parameter int unsigned QueueDepth = bnnf_pkg::QueueDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  bnnf_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output bnnf_pkg::out_item_t               out_item_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bnnf_pkg::PAddrW-1:0]       paddr,
  input  logic [bnnf_pkg::PDataW-1:0]       pwdata,
  output logic [bnnf_pkg::PDataW-1:0]       prdata,
  output logic                              pready
);
  import bnnf_pkg::*;

  logic [HeightW-1:0] height_q, height_d;
  masks_t             masks;
  logic               reg_hit;
  logic               q_push, q_full, q_pop, q_valid;
  entry_t             q_in, q_head;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PAddrW-1] == RegHeight);
  assign prdata  = reg_hit ? PDataW'(height_q) : '0;
  assign masks   = masks_from_height(height_q);

  always_comb begin
    height_d = height_q;
    if (psel && penable && pwrite && reg_hit) begin
      height_d = pwdata[HeightW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= HeightReset;
    end else begin
      height_q <= height_d;
    end
  end

  bnnf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .masks_i    (masks),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_in)
  );

  bnnf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_head)
  );

  bnnf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .masks_i      (masks),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

// ----- sim/binary_neighbor_noise_filter_unit_checker.sv -----
// Column filter predictor and result checker for the binary neighbor noise filter.
`timescale 1ns / 1ps

module binary_neighbor_noise_filter_unit_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  bnnf_pkg::in_item_t            in_item_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  bnnf_pkg::out_item_t           out_item_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [bnnf_pkg::PAddrW-1:0]   paddr_i,
  input  logic [bnnf_pkg::PDataW-1:0]   pwdata_i,
  output int                            pending_o,
  output int                            mismatch_count_o
);
  import bnnf_pkg::*;

  localparam logic [PAddrW-1:0] HeightAddr = PAddrW'(4 * RegHeight);

  logic [HeightW-1:0] height;
  logic [ColW-1:0]    orig_prev;
  logic [ColW-1:0]    orig_prev2;
  logic [ColW-1:0]    eroded_prev;
  logic [ColW-1:0]    emitted_prev;
  kind_e              next_kind;
  out_item_t          filtered_expected [$];
  int                 mismatches = 0;

  assign mismatch_count_o = mismatches;

  function automatic int rows_in_use();
    return (height > HeightW'(MaxRows)) ? int'(MaxRows) : int'(height);
  endfunction

  function automatic logic [ColW-1:0] rows_mask();
    int h;
    h = rows_in_use();
    if (h >= ColW) begin
      return '1;
    end
    return (ColW'(1) << h) - ColW'(1);
  endfunction

  function automatic logic [ColW-1:0] inner_rows();
    int h;
    h = rows_in_use();
    if (h < MinHeight) begin
      return '0;
    end
    return rows_mask() & ~ColW'(1) & ~(ColW'(1) << (h - 1));
  endfunction

  // Clear white pixels with a black vertical neighbor or black on both sides.
  function automatic logic [ColW-1:0] erode_column(input logic [ColW-1:0] l,
                                                   input logic [ColW-1:0] c,
                                                   input logic [ColW-1:0] r);
    logic [ColW-1:0] kill;
    kill = ~(c << 1) | ~(c >> 1) | (~l & ~r);
    return c & ~(inner_rows() & kill);
  endfunction

  // Clear isolated white pixels, scanning rows top to bottom in place.
  function automatic logic [ColW-1:0] drop_isolated(input logic [ColW-1:0] l,
                                                    input logic [ColW-1:0] c,
                                                    input logic [ColW-1:0] r);
    int h;
    h = rows_in_use();
    for (int j = 1; j + 1 < h && j < ColW - 1; j++) begin
      if (c[j] && !c[j-1] && !c[j+1] && !l[j] && !r[j]) begin
        c[j] = 1'b0;
      end
    end
    return c;
  endfunction

  function automatic void wipe_image();
    orig_prev    = '0;
    orig_prev2   = '0;
    eroded_prev  = '0;
    emitted_prev = '0;
    next_kind    = KindFirst;
  endfunction

  function automatic void push_column(input logic [ColW-1:0] bits, input logic fin);
    filtered_expected.push_back(out_item_t'{filtered_bits: bits, final_column: fin});
  endfunction

  task automatic report_mismatch(input string what, input logic [ColW-1:0] got,
                                 input logic [ColW-1:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic predict_filtered(input in_item_t it);
    logic [ColW-1:0] col;
    logic [ColW-1:0] mid;
    logic [ColW-1:0] emitted;
    col = it.column_bits & rows_mask();
    case (next_kind)
      KindFirst: begin
        if (it.last_column) begin
          push_column(col, 1'b1);
          wipe_image();
        end else begin
          orig_prev = col;
          next_kind = KindSecond;
        end
      end
      KindSecond: begin
        if (it.last_column) begin
          push_column(orig_prev, 1'b0);
          push_column(col, 1'b1);
          wipe_image();
        end else begin
          eroded_prev = orig_prev;
          orig_prev2  = orig_prev;
          orig_prev   = col;
          next_kind   = KindThird;
        end
      end
      default: begin
        mid = erode_column(orig_prev2, orig_prev, col);
        if (next_kind == KindThird) begin
          emitted = eroded_prev;
        end else begin
          emitted = drop_isolated(emitted_prev, eroded_prev, mid);
        end
        push_column(emitted & rows_mask(), 1'b0);
        if (it.last_column) begin
          push_column(drop_isolated(emitted, mid, col) & rows_mask(), 1'b0);
          push_column(col, 1'b1);
          wipe_image();
        end else begin
          emitted_prev = emitted;
          eroded_prev  = mid;
          orig_prev2   = orig_prev;
          orig_prev    = col;
          next_kind    = KindSteady;
        end
      end
    endcase
  endtask

  task automatic check_column(input out_item_t got);
    out_item_t want;
    if (filtered_expected.size() == 0) begin
      report_mismatch("column with nothing expected", got.filtered_bits, '0);
    end else begin
      want = filtered_expected.pop_front();
      if (got.filtered_bits !== want.filtered_bits) begin
        report_mismatch("filtered_bits", got.filtered_bits, want.filtered_bits);
      end
      if (got.final_column !== want.final_column) begin
        report_mismatch("final_column", ColW'(got.final_column), ColW'(want.final_column));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height = HeightReset;
      wipe_image();
      filtered_expected.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_column(out_item_i);
      end
      if (in_valid_i && !in_stall_i) begin
        predict_filtered(in_item_i);
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == HeightAddr) begin
        height = pwdata_i[HeightW-1:0];
      end
      pending_o <= filtered_expected.size();
    end
  end

endmodule

// ----- sim/binary_neighbor_noise_filter_unit_tb.sv -----
// Stimulus, clocking and verdict for the binary neighbor noise filter testbench.
`timescale 1ns / 1ps

module binary_neighbor_noise_filter_unit_tb;
  import bnnf_pkg::*;

  localparam logic [PAddrW-1:0] HeightAddr = PAddrW'(4 * RegHeight);
  localparam int                QuietLimit = 2000;
  localparam int                PhaseItems = 19;

  typedef enum int {
    ColRandom,
    ColDense,
    ColSolidHoles,
    ColSparse,
    ColWhite,
    ColBlack
  } pattern_e;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_item;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PAddrW-1:0]  paddr;
  logic [PDataW-1:0]  pwdata;
  logic [PDataW-1:0]  prdata;
  logic               pready;
  int                 pending;
  int                 mismatch_count;

  int                 burst_left = 0;
  int                 items_sent = 0;
  int                 quiet = 0;
  int                 stall_mode;
  int                 stall_span;
  int                 stall_tick = 0;
  int                 phase_start;
  int                 phase_heights [$] = '{3, 127, 0, 1, 2, 17, 63, 64, 40};

  binary_neighbor_noise_filter_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  binary_neighbor_noise_filter_unit_checker filter_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_item_i       (out_item),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pending_o        (pending),
    .mismatch_count_o (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 80);
      repeat (stall_span) begin
        @(posedge clk);
        stall_tick++;
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((stall_tick % 7) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (rst_n) begin
      quiet <= quiet + 1;
    end
    if (quiet >= QuietLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [ColW-1:0] make_column(input pattern_e style);
    logic [ColW-1:0] a;
    logic [ColW-1:0] b;
    logic [ColW-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case (style)
      ColRandom:     return a;
      ColDense:      return ~(a & b);
      ColSolidHoles: return ~(a & b & c);
      ColSparse:     return a & b;
      ColWhite:      return '1;
      default:       return '0;
    endcase
  endfunction

  task automatic send_column(input logic [ColW-1:0] bits, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item  <= in_item_t'{column_bits: bits, last_column: last};
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
  endtask

  task automatic random_image();
    int       ncols;
    int       pick;
    pattern_e base;
    pattern_e style;
    pick  = $urandom_range(0, 9);
    ncols = (pick == 0) ? 1 : (pick == 1) ? 2 : $urandom_range(3, 12);
    pick  = $urandom_range(0, 9);
    base  = (pick < 4) ? ColDense : (pick < 7) ? ColSolidHoles : pattern_e'($urandom_range(0, 5));
    for (int i = 0; i < ncols; i++) begin
      style = ($urandom_range(0, 4) == 0) ? pattern_e'($urandom_range(0, 5)) : base;
      send_column(make_column(style), i == ncols - 1);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_height(input logic [HeightW-1:0] h);
    logic [PDataW-1:0] word;
    word = $urandom;
    word[HeightW-1:0] = h;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HeightAddr;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_column('1, 1'b1);
    send_column('0, 1'b1);
    send_column('1, 1'b0);
    send_column({32{2'b01}}, 1'b1);
    send_column('1, 1'b0);
    send_column('1, 1'b0);
    send_column('1, 1'b1);
    send_column('1, 1'b0);
    send_column({32{2'b10}}, 1'b0);
    send_column({32{2'b01}}, 1'b0);
    send_column('1, 1'b1);
    send_column('0, 1'b0);
    send_column(ColW'(1) << 5, 1'b0);
    send_column(ColW'(7) << 4, 1'b0);
    send_column('0, 1'b0);
    send_column('0, 1'b1);
    send_column('1, 1'b0);
    send_column(~(ColW'(1) << 32), 1'b0);
    send_column('1, 1'b0);
    send_column('1, 1'b1);
    settle();

    foreach (phase_heights[i]) begin
      write_height(HeightW'(phase_heights[i]));
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        random_image();
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
